FILE: rtl/core/rmst_pkg.sv
package rmst_pkg;

	localparam int LEAVES  = 1024;
	localparam int LVL_W   = $clog2(LEAVES);
	localparam int NODE_AW = LVL_W + 1;          // node memory address, heap index 1..2*LEAVES-1
	localparam int NODES   = 2 * LEAVES;
	localparam int HEAP_W  = NODE_AW + 1;        // walk indices reach 2*LEAVES
	localparam int POS_W   = 10;
	localparam int HI_W    = 11;
	localparam int VAL_W   = 32;

	localparam logic signed [VAL_W-1:0] TREE_INF = {1'b0, {(VAL_W-1){1'b1}}};

	localparam logic OP_SET   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic                    opcode;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        range_lo;
		logic [HI_W-1:0]         range_hi;
	} cmd_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] minimum;
		logic                    empty_range;
	} res_t;

endpackage

FILE: rtl/core/rmst_if.sv
interface rmst_req_if;
	logic                             valid;
	logic                             ready;
	logic                             opcode;
	logic [rmst_pkg::POS_W-1:0]       position;
	logic signed [rmst_pkg::VAL_W-1:0] value;
	logic [rmst_pkg::POS_W-1:0]       range_lo;
	logic [rmst_pkg::HI_W-1:0]        range_hi;

	modport source (output valid, opcode, position, value, range_lo, range_hi, input ready);
	modport sink (input valid, opcode, position, value, range_lo, range_hi, output ready);
endinterface

interface rmst_rsp_if;
	logic                             valid;
	logic                             ready;
	logic signed [rmst_pkg::VAL_W-1:0] minimum;
	logic                             empty_range;

	modport source (output valid, minimum, empty_range, input ready);
	modport sink (input valid, minimum, empty_range, output ready);
endinterface

FILE: rtl/core/rmst_engine.sv
module rmst_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  rmst_pkg::cmd_t       cmd,
	output logic                 idle,
	output logic                 done,
	output rmst_pkg::res_t       res,
	input  logic                 res_take
);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_UA   = 3'd2;
	localparam logic [2:0] ST_UB   = 3'd3;
	localparam logic [2:0] ST_QL   = 3'd4;
	localparam logic [2:0] ST_QR   = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	localparam int AW = rmst_pkg::NODE_AW;
	localparam int HW = rmst_pkg::HEAP_W;
	localparam int VW = rmst_pkg::VAL_W;
	localparam logic [HW-1:0] LEAF_BASE = HW'(rmst_pkg::LEAVES);
	localparam logic [HW-1:0] ROOT      = HW'(1);

	logic [2:0]           state_q;
	logic [AW-1:0]        clr_q;
	logic signed [VW-1:0] cur_q;
	logic signed [VW-1:0] rd_q;
	logic [HW-1:0]        l_q;    // left walk index, also the node index during an update
	logic [HW-1:0]        r_q;
	logic                 pend_q;
	logic                 empty_q;

	logic signed [VW-1:0] mem [0:rmst_pkg::NODES-1];

	logic                 we;
	logic [AW-1:0]        wa;
	logic signed [VW-1:0] wd;
	logic                 re;
	logic [AW-1:0]        ra;

	logic signed [VW-1:0] mn;
	logic signed [VW-1:0] acc;
	logic [HW-1:0]        leaf;
	logic                 pos_ok;
	logic [HW-1:0]        hi_c;
	logic [HW-1:0]        r_dec;
	logic [HW-1:0]        sib;
	logic [HW-1:0]        parent;

	assign mn     = (rd_q < cur_q) ? rd_q : cur_q;
	assign acc    = pend_q ? mn : cur_q;
	assign leaf   = LEAF_BASE + HW'(cmd.position);
	assign pos_ok = HW'(cmd.position) < LEAF_BASE;
	assign hi_c   = (HW'(cmd.range_hi) > LEAF_BASE) ? LEAF_BASE : HW'(cmd.range_hi);
	assign r_dec  = r_q - HW'(r_q[0]);
	assign sib    = l_q ^ ROOT;
	assign parent = l_q >> 1;

	assign idle = (state_q == ST_IDLE);
	assign done = (state_q == ST_DONE);
	assign res  = '{minimum: cur_q, empty_range: empty_q};

	always_comb begin
		we = 1'b0;
		wa = l_q[AW-1:0];
		wd = mn;
		re = 1'b0;
		ra = l_q[AW-1:0];
		case (state_q)
			ST_CLR: begin
				we = 1'b1;
				wa = clr_q;
				wd = rmst_pkg::TREE_INF;
			end
			ST_IDLE: begin
				if (start && cmd.opcode == rmst_pkg::OP_SET && pos_ok) begin
					we = 1'b1;
					wa = leaf[AW-1:0];
					wd = cmd.value;
				end
			end
			ST_UA: begin
				if (l_q != ROOT) begin
					re = 1'b1;
					ra = sib[AW-1:0];
				end
			end
			ST_UB: begin
				we = 1'b1;
				wa = parent[AW-1:0];
				wd = mn;
			end
			ST_QL: begin
				re = (l_q < r_q) && l_q[0];
				ra = l_q[AW-1:0];
			end
			ST_QR: begin
				re = r_q[0];
				ra = r_dec[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			pend_q  <= 1'b0;
			cur_q   <= rmst_pkg::TREE_INF;
			l_q     <= ROOT;
			r_q     <= ROOT;
			empty_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == {AW{1'b1}}) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						pend_q <= 1'b0;
						if (cmd.opcode == rmst_pkg::OP_SET) begin
							l_q   <= leaf;
							cur_q <= cmd.value;
							if (pos_ok) state_q <= ST_UA;
						end else begin
							l_q     <= HW'(cmd.range_lo) + LEAF_BASE;
							r_q     <= hi_c + LEAF_BASE;
							cur_q   <= rmst_pkg::TREE_INF;
							empty_q <= (cmd.range_hi <= rmst_pkg::HI_W'(cmd.range_lo));
							state_q <= ST_QL;
						end
					end
				end
				ST_UA: begin
					if (l_q == ROOT) state_q <= ST_IDLE;
					else state_q <= ST_UB;
				end
				ST_UB: begin
					cur_q   <= mn;
					l_q     <= parent;
					state_q <= ST_UA;
				end
				ST_QL: begin
					cur_q <= acc;
					if (l_q < r_q) begin
						pend_q  <= l_q[0];
						if (l_q[0]) l_q <= l_q + HW'(1);
						state_q <= ST_QR;
					end else begin
						pend_q  <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				ST_QR: begin
					cur_q   <= acc;
					pend_q  <= r_q[0];
					l_q     <= l_q >> 1;
					r_q     <= r_dec >> 1;
					state_q <= ST_QL;
				end
				ST_DONE: begin
					if (res_take) state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLR;
			endcase
		end
	end

	// node memory has a single port pair; the sequencer never reads and writes together
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n) we |-> !re)
		else $error("node memory read and write in one cycle");

	a_no_read_clr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLR |-> !re && !start)
		else $error("activity during clearing pass");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n) start |-> idle)
		else $error("item started while busy");

	a_upd_node: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UA || state_q == ST_UB) |-> l_q != '0 && l_q < HW'(rmst_pkg::NODES))
		else $error("update walk left the tree");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		done && !res_take |=> done && $stable(res))
		else $error("result changed before it was taken");

endmodule

FILE: rtl/core/range_min_segment_tree.sv
// Range-minimum segment tree over LEAVES (1024) signed 32-bit leaves, one item at a time.
// After reset the block fills the node memory with the maximum value (infinity) and holds
// req.ready low meanwhile. A set beat then walks from the leaf to the root with one sibling
// read and one parent write per level. A query beat walks both range ends up the tree, with
// at most one read per side at each level, before its result is ready; both walks are bound
// by the single read port of the node memory. The result sits in an output register, so the
// next beat is taken while it waits on rsp. Sets give no response beat.
module range_min_segment_tree (
	input  logic        clk,
	input  logic        arst_n,
	rmst_req_if.sink    req,
	rmst_rsp_if.source  rsp
);

	rmst_pkg::cmd_t cmd;
	rmst_pkg::res_t res;
	logic           start;
	logic           idle;
	logic           done;
	logic           take;

	logic                                out_valid_q;
	logic signed [rmst_pkg::VAL_W-1:0]   out_min_q;
	logic                                out_empty_q;

	assign cmd = '{opcode: req.opcode, position: req.position, value: req.value,
		range_lo: req.range_lo, range_hi: req.range_hi};

	assign req.ready = idle;
	assign start     = req.valid && idle;
	assign take      = done && (!out_valid_q || rsp.ready);

	rmst_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (cmd),
		.idle     (idle),
		.done     (done),
		.res      (res),
		.res_take (take)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_min_q   <= res.minimum;
			out_empty_q <= res.empty_range;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.minimum     = out_min_q;
	assign rsp.empty_range = out_empty_q;

endmodule
